### rtl/hsbn_pkg.sv
// Package for the serial bus node: constants, enums, item, result and configuration types.
// No dependencies.
`timescale 1ns / 1ps
package hsbn_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int BUF_AW = $clog2(BUF_DEPTH);
    localparam logic [15:0] ACK_PAUSE_TICKS = 16'd10;
    localparam logic [15:0] READ_PAUSE_TICKS = 16'd1;
    localparam logic [8:0] BUF_DEPTH_W = 9'(BUF_DEPTH);

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_LOAD = 2'd1,
        KIND_SEND = 2'd2,
        KIND_RECV = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_NO_TRY    = 3'd1,
        ERR_NO_ACK    = 3'd2,
        ERR_BUS_BUSY  = 3'd3,
        ERR_CLK_LOW   = 3'd4,
        ERR_CLK_HIGH  = 3'd5
    } err_t;

    typedef enum logic [4:0] {
        P_IDLE, P_S_ACT, P_S_STROBE, P_S_ACK, P_S_START, P_S_HOLD, P_S_LOW,
        P_S_BYTE, P_S_SETTLE, P_R_DAT, P_R_ACKP, P_R_STROBE, P_R_LOW, P_R_READ,
        P_R_FAILP, P_R_HIGH, P_R_SETTLE
    } phase_t;

    typedef enum logic [2:0] {
        REG_RETRIES, REG_TO_TICKS, REG_TO_LOOPS, REG_STROBE,
        REG_BIT_PAUSE, REG_BYTE_PAUSE, REG_SETTLE, REG_START_PAUSE
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       clk_level;
        logic       act_level;
        logic       dat_level;
        logic [5:0] load_index;
        logic [7:0] load_value;
    } item_t;

    typedef struct packed {
        logic       clk_drive;
        logic       clk_enable;
        logic       act_drive;
        logic       act_enable;
        logic       dat_drive;
        logic       dat_enable;
        logic       busy_res;
        logic       done_res;
        logic [2:0] error_code;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_value;
    } result_t;

    typedef struct packed {
        logic [7:0]  max_send_retries;
        logic [15:0] timeout_ticks;
        logic [7:0]  timeout_loops;
        logic [15:0] strobe_ticks;
        logic [15:0] bit_pause_ticks;
        logic [15:0] byte_pause_ticks;
        logic [15:0] settle_ticks;
        logic [15:0] start_pause_ticks;
    } cfg_t;

endpackage

### rtl/hsbn_if.sv
// Channel interfaces: item, result and configuration write.
// Depends on hsbn_pkg.
`timescale 1ns / 1ps
interface hsbn_item_if;
    import hsbn_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hsbn_result_if;
    import hsbn_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hsbn_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

### rtl/hsbn_cfg_regs.sv
// Configuration register file for the bus node.
// Depends on hsbn_pkg and hsbn_if.
`timescale 1ns / 1ps
module hsbn_cfg_regs (
    input  logic         clk,
    input  logic         rst_n,
    hsbn_cfg_if.sink     cfg,
    output hsbn_pkg::cfg_t regs
);
    import hsbn_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '{8'd3, 16'd10000, 8'd5, 16'd10, 16'd5, 16'd10, 16'd20, 16'd20};
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_RETRIES:     regs_reg.max_send_retries  <= cfg.wdata[7:0];
                REG_TO_TICKS:    regs_reg.timeout_ticks     <= cfg.wdata;
                REG_TO_LOOPS:    regs_reg.timeout_loops     <= cfg.wdata[7:0];
                REG_STROBE:      regs_reg.strobe_ticks      <= cfg.wdata;
                REG_BIT_PAUSE:   regs_reg.bit_pause_ticks   <= cfg.wdata;
                REG_BYTE_PAUSE:  regs_reg.byte_pause_ticks  <= cfg.wdata;
                REG_SETTLE:      regs_reg.settle_ticks      <= cfg.wdata;
                REG_START_PAUSE: regs_reg.start_pause_ticks <= cfg.wdata;
                default:         regs_reg <= regs_reg;
            endcase
        end
    end
endmodule

### rtl/hsbn_core.sv
// Bus node sequencer: one item per cycle while step is high, from the item input to a combinational result.
// Depends on hsbn_pkg.
`timescale 1ns / 1ps
module hsbn_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  hsbn_pkg::item_t   item,
    input  hsbn_pkg::cfg_t    cfg,
    output hsbn_pkg::result_t res
);
    import hsbn_pkg::*;

    logic [7:0] buf_mem [BUF_DEPTH];
    logic [BUF_DEPTH-1:0] buf_vld_reg;
    logic [7:0] buf0_reg;
    logic [7:0] rd_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  byte_pos_reg, byte_pos_next;
    logic [2:0]  bit_pos_reg, bit_pos_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  rx_len_reg, rx_len_next;
    logic [15:0] delay_reg, delay_next;
    logic [15:0] wtick_reg, wtick_next;
    logic [7:0]  wloop_reg, wloop_next;
    logic [7:0]  attempt_reg, attempt_next;
    err_t        err_reg, err_next;

    logic [7:0] buf0, buf_at;
    logic [8:0] send_len;
    logic       done;
    logic       w_match, w_hit, w_fail, d_done, send_side, tx_bit;
    logic [15:0] wtick_inc;
    logic [7:0]  byte_inc;
    logic       load_wr;
    logic       load_ok;
    logic [BUF_AW-1:0] rd_addr;

    // entry 0 kept in its own register; rd_reg holds the byte the next send step needs
    assign buf0   = buf0_reg;
    assign buf_at = rd_reg;
    assign send_len = ({1'b0, buf0} > BUF_DEPTH_W) ? BUF_DEPTH_W : {1'b0, buf0};
    assign load_wr = step && item.kind == KIND_LOAD;
    assign load_ok = load_wr && {3'b0, item.load_index} < BUF_DEPTH_W;
    assign wtick_inc = wtick_reg + 16'd1;
    assign byte_inc = byte_pos_reg + 8'd1;
    assign d_done = delay_reg == 16'd0;
    assign rd_addr = (phase_next == P_S_BYTE)
                     ? byte_pos_next[BUF_AW-1:0] + BUF_AW'(1) : byte_pos_next[BUF_AW-1:0];

    always_comb
    begin
        unique case (phase_reg)
            P_S_ACT:  w_match = item.act_level;
            P_S_ACK:  w_match = !item.dat_level;
            P_R_DAT:  w_match = item.dat_level;
            P_R_LOW:  w_match = !item.clk_level;
            default:  w_match = item.clk_level;
        endcase
        w_hit  = w_match;
        w_fail = !w_match && wtick_inc >= cfg.timeout_ticks && wloop_reg >= cfg.timeout_loops;
    end

    always_comb
    begin
        phase_next = phase_reg;
        byte_pos_next = byte_pos_reg;
        bit_pos_next = bit_pos_reg;
        shift_next = shift_reg;
        rx_len_next = rx_len_reg;
        delay_next = delay_reg;
        wtick_next = wtick_reg;
        wloop_next = wloop_reg;
        attempt_next = attempt_reg;
        err_next = err_reg;
        done = 1'b0;
        res = '0;
        if (step)
        begin
            if (item.kind == KIND_TICK)
            begin
                // wait counters advance on non-matching ticks in wait phases
                if ((phase_reg == P_S_ACT || phase_reg == P_S_ACK || phase_reg == P_R_DAT
                     || phase_reg == P_R_LOW || phase_reg == P_R_HIGH) && !w_match)
                begin
                    if (wtick_inc >= cfg.timeout_ticks)
                    begin
                        wtick_next = '0;
                        if (wloop_reg < cfg.timeout_loops)
                            wloop_next = wloop_reg + 8'd1;
                    end
                    else
                        wtick_next = wtick_inc;
                end
                if (!d_done)
                    delay_next = delay_reg - 16'd1;
                unique case (phase_reg)
                    P_S_ACT:
                    begin
                        if (w_hit)
                        begin
                            phase_next = P_S_STROBE; delay_next = cfg.strobe_ticks;
                        end
                        else if (w_fail)
                        begin
                            attempt_next = attempt_reg + 8'd1; err_next = ERR_BUS_BUSY;
                            if (attempt_next < cfg.max_send_retries)
                            begin
                                phase_next = P_S_ACT; wtick_next = '0; wloop_next = '0;
                            end
                            else
                            begin
                                phase_next = P_IDLE; done = 1'b1;
                            end
                        end
                    end
                    P_S_STROBE:
                        if (d_done)
                        begin
                            phase_next = P_S_ACK; wtick_next = '0; wloop_next = '0;
                        end
                    P_S_ACK:
                    begin
                        if (w_hit)
                        begin
                            byte_pos_next = '0; phase_next = P_S_START;
                            delay_next = cfg.start_pause_ticks;
                        end
                        else if (w_fail)
                        begin
                            attempt_next = attempt_reg + 8'd1; err_next = ERR_NO_ACK;
                            if (attempt_next < cfg.max_send_retries)
                            begin
                                phase_next = P_S_ACT; wtick_next = '0; wloop_next = '0;
                            end
                            else
                            begin
                                phase_next = P_IDLE; done = 1'b1;
                            end
                        end
                    end
                    P_S_START, P_S_BYTE:
                        if (d_done)
                        begin
                            if (phase_reg == P_S_BYTE)
                                byte_pos_next = byte_inc;
                            if ({1'b0, byte_pos_next} < send_len)
                            begin
                                shift_next = buf_at; bit_pos_next = '0;
                                phase_next = P_S_HOLD; delay_next = cfg.bit_pause_ticks;
                            end
                            else
                            begin
                                phase_next = P_S_SETTLE; delay_next = cfg.settle_ticks;
                            end
                        end
                    P_S_HOLD:
                        if (d_done)
                        begin
                            phase_next = P_S_LOW; delay_next = cfg.bit_pause_ticks;
                        end
                    P_S_LOW:
                        if (d_done)
                        begin
                            if (bit_pos_reg == 3'd7)
                            begin
                                phase_next = P_S_BYTE; delay_next = cfg.byte_pause_ticks;
                            end
                            else
                            begin
                                bit_pos_next = bit_pos_reg + 3'd1;
                                phase_next = P_S_HOLD; delay_next = cfg.bit_pause_ticks;
                            end
                        end
                    P_S_SETTLE:
                        if (d_done)
                        begin
                            attempt_next = attempt_reg + 8'd1; err_next = ERR_OK;
                            phase_next = P_IDLE; done = 1'b1;
                        end
                    P_R_DAT:
                        if (w_hit || w_fail)
                        begin
                            phase_next = P_R_ACKP; delay_next = ACK_PAUSE_TICKS;
                        end
                    P_R_ACKP:
                        if (d_done)
                        begin
                            phase_next = P_R_STROBE; delay_next = cfg.strobe_ticks;
                        end
                    P_R_STROBE:
                        if (d_done)
                        begin
                            phase_next = P_R_LOW; wtick_next = '0; wloop_next = '0;
                        end
                    P_R_LOW:
                    begin
                        if (w_hit)
                        begin
                            phase_next = P_R_READ; delay_next = READ_PAUSE_TICKS;
                        end
                        else if (w_fail)
                        begin
                            phase_next = P_R_FAILP; delay_next = READ_PAUSE_TICKS;
                        end
                    end
                    P_R_READ:
                        if (d_done)
                        begin
                            if (item.dat_level)
                                shift_next = shift_reg | (8'd1 << bit_pos_reg);
                            phase_next = P_R_HIGH; wtick_next = '0; wloop_next = '0;
                        end
                    P_R_FAILP:
                        if (d_done)
                        begin
                            err_next = ERR_CLK_LOW; phase_next = P_R_SETTLE;
                            delay_next = cfg.settle_ticks;
                        end
                    P_R_HIGH:
                    begin
                        if (w_fail)
                        begin
                            err_next = ERR_CLK_HIGH; phase_next = P_R_SETTLE;
                            delay_next = cfg.settle_ticks;
                        end
                        else if (w_hit)
                        begin
                            if (bit_pos_reg != 3'd7)
                            begin
                                bit_pos_next = bit_pos_reg + 3'd1; phase_next = P_R_LOW;
                                wtick_next = '0; wloop_next = '0;
                            end
                            else
                            begin
                                res.rx_valid = 1'b1;
                                res.rx_index = byte_pos_reg;
                                res.rx_value = shift_reg;
                                if (byte_pos_reg == 8'd0)
                                    rx_len_next = shift_reg;
                                byte_pos_next = byte_inc;
                                if (byte_inc < rx_len_next)
                                begin
                                    shift_next = '0; bit_pos_next = '0; phase_next = P_R_LOW;
                                    wtick_next = '0; wloop_next = '0;
                                end
                                else
                                begin
                                    err_next = ERR_OK; phase_next = P_R_SETTLE;
                                    delay_next = cfg.settle_ticks;
                                end
                            end
                        end
                    end
                    P_R_SETTLE:
                        if (d_done)
                        begin
                            phase_next = P_IDLE; done = 1'b1;
                        end
                    default:
                        phase_next = P_IDLE;
                endcase
            end
            else if (item.kind != KIND_LOAD && phase_reg == P_IDLE)
            begin
                wtick_next = '0; wloop_next = '0;
                if (item.kind == KIND_SEND)
                begin
                    attempt_next = '0;
                    if (cfg.max_send_retries == 8'd0)
                    begin
                        err_next = ERR_NO_TRY; done = 1'b1;
                    end
                    else
                        phase_next = P_S_ACT;
                end
                else
                begin
                    byte_pos_next = '0; bit_pos_next = '0; shift_next = '0;
                    rx_len_next = '0; phase_next = P_R_DAT;
                end
            end
        end
        send_side = phase_next >= P_S_STROBE && phase_next <= P_S_SETTLE;
        tx_bit = shift_next[bit_pos_next];
        res.clk_drive  = phase_next != P_S_LOW;
        res.clk_enable = send_side;
        res.act_drive  = !send_side;
        res.act_enable = send_side;
        case (phase_next)
            P_S_STROBE, P_R_STROBE:
            begin
                res.dat_drive = 1'b0; res.dat_enable = 1'b1;
            end
            P_S_START, P_R_ACKP:
            begin
                res.dat_drive = 1'b1; res.dat_enable = 1'b1;
            end
            P_S_HOLD, P_S_LOW, P_S_BYTE:
            begin
                res.dat_drive = tx_bit; res.dat_enable = 1'b1;
            end
            default:
            begin
                res.dat_drive = 1'b1; res.dat_enable = 1'b0;
            end
        endcase
        res.busy_res = phase_next != P_IDLE;
        res.done_res = done;
        res.error_code = err_next;
    end

    // read address follows the state after this item; a load to it is forwarded
    always_ff @(posedge clk)
    begin
        if (load_ok)
            buf_mem[item.load_index[BUF_AW-1:0]] <= item.load_value;
        if (step)
        begin
            if (load_ok && item.load_index[BUF_AW-1:0] == rd_addr)
                rd_reg <= item.load_value;
            else
                rd_reg <= buf_vld_reg[rd_addr] ? buf_mem[rd_addr] : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_vld_reg <= '0;
            buf0_reg <= '0;
            phase_reg <= P_IDLE;
            byte_pos_reg <= '0;
            bit_pos_reg <= '0;
            shift_reg <= '0;
            rx_len_reg <= '0;
            delay_reg <= '0;
            wtick_reg <= '0;
            wloop_reg <= '0;
            attempt_reg <= '0;
            err_reg <= ERR_NO_TRY;
        end
        else if (step)
        begin
            if (load_ok)
                buf_vld_reg[item.load_index[BUF_AW-1:0]] <= 1'b1;
            if (load_ok && item.load_index == '0)
                buf0_reg <= item.load_value;
            phase_reg <= phase_next;
            byte_pos_reg <= byte_pos_next;
            bit_pos_reg <= bit_pos_next;
            shift_reg <= shift_next;
            rx_len_reg <= rx_len_next;
            delay_reg <= delay_next;
            wtick_reg <= wtick_next;
            wloop_reg <= wloop_next;
            attempt_reg <= attempt_next;
            err_reg <= err_next;
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.done_res |-> !res.busy_res) else $error("done while busy");
    a_rx_in_recv: assert property (@(posedge clk) disable iff (!rst_n)
        res.rx_valid |-> phase_reg == P_R_HIGH) else $error("rx byte outside receive");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg)) else $error("phase moved without item");
endmodule

### rtl/handshake_serial_bus_node.sv
// Top level of the serial bus node: sequencer and result register.
// Depends on hsbn_pkg, hsbn_if, hsbn_cfg_regs, hsbn_core.
//
//  channel | dir | contents
//  in_ch   | in  | kind, line levels, load index/value
//  out_ch  | out | line drives/enables, busy, done, error, rx byte
//  cfg_ch  | in  | register index, write data
//
// One item per cycle unless out_ch stalls; results come in the cycle after.
// A transfer is taken whenever the result register is empty or being drained.
// Reset clears all control state; the send buffer reads zero until written.
`timescale 1ns / 1ps
module handshake_serial_bus_node (
    input  logic         clk,
    input  logic         rst_n,
    hsbn_item_if.sink    in_ch,
    hsbn_result_if.source out_ch,
    hsbn_cfg_if.sink     cfg_ch
);
    import hsbn_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_reg;
    logic    out_vld_reg;
    logic    step;

    // accept whenever the result slot is empty or being taken this cycle
    assign in_ch.ready = !out_vld_reg || out_ch.ready;
    assign step = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_vld_reg;
    assign out_ch.data = out_reg;

    hsbn_cfg_regs u_cfg (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_ch),
        .regs (cfg)
    );

    hsbn_core u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .item (in_ch.data),
        .cfg  (cfg),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (in_ch.ready)
            out_vld_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= res;
    end
endmodule
